@@ hdl/lcrs_pkg.sv @@
`default_nettype none

package lcrs_pkg;

	// field widths
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned CHECK_W    = 16;
	localparam int unsigned TIMEOUT_W  = 20;
	localparam int unsigned RETRY_W    = 4;
	localparam int unsigned RECOVERY_W = 24;
	localparam int unsigned COLOUR_W   = 16;
	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 24;

	// register reset values
	localparam logic [CHECK_W-1:0]    CHECK_INTERVAL_RST  = CHECK_W'(5000);
	localparam logic [TIMEOUT_W-1:0]  CONNECT_TIMEOUT_RST = TIMEOUT_W'(10000);
	localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST     = RETRY_W'(3);
	localparam logic [RECOVERY_W-1:0] RECOVERY_RST        = RECOVERY_W'(120000);

	// retry counter saturation
	localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

	// indicator colours
	localparam logic [COLOUR_W-1:0] COLOUR_UP   = 16'h001F;
	localparam logic [COLOUR_W-1:0] COLOUR_BUSY = 16'h07FF;
	localparam logic [COLOUR_W-1:0] COLOUR_DOWN = 16'h07E0;

	typedef enum logic [MODE_W-1:0] {
		LINK_DISC       = 3'd0,
		LINK_CONNECTING = 3'd1,
		LINK_CONNECTED  = 3'd2,
		LINK_RECONN     = 3'd3,
		LINK_FAILED     = 3'd4
	} link_mode_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CHECK     = 2'd0,
		OP_ADDR_ACQ  = 2'd1,
		OP_LINK_LOST = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_INTERVAL  = 4'd0,
		CFG_CONNECT_TIMEOUT = 4'd1,
		CFG_MAX_RETRIES     = 4'd2,
		CFG_RECOVERY        = 4'd3
	} cfg_reg_t;

	// configuration as seen by the supervisor
	typedef struct packed {
		logic [CHECK_W-1:0]    check_interval;
		logic [TIMEOUT_W-1:0]  connect_timeout;
		logic [RETRY_W-1:0]    max_retries;
		logic [RECOVERY_W-1:0] recovery;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [MODE_W-1:0]   link_state;
		logic                start_connect;
		logic                resync_time;
		logic [COLOUR_W-1:0] indicator_colour;
		logic                redraw_status;
	} result_t;

	function automatic logic [COLOUR_W-1:0] colour_for(input link_mode_t mode);
		logic [COLOUR_W-1:0] c;
		case (mode)
			LINK_CONNECTED:  c = COLOUR_UP;
			LINK_CONNECTING: c = COLOUR_BUSY;
			LINK_RECONN:     c = COLOUR_BUSY;
			LINK_FAILED:     c = COLOUR_DOWN;
			default:         c = COLOUR_UP;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hdl/lcrs_if.sv @@
`default_nettype none

// input item channel
interface lcrs_item_if
	import lcrs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TIME_W-1:0]   now_ms;
	logic                addr_changed;

	modport source (output valid, output opcode, output now_ms, output addr_changed,
		input ready);
	modport sink (input valid, input opcode, input now_ms, input addr_changed,
		output ready);
endinterface

// result item channel
interface lcrs_result_if
	import lcrs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   link_state;
	logic                start_connect;
	logic                resync_time;
	logic [COLOUR_W-1:0] indicator_colour;
	logic                redraw_status;

	modport source (output valid, output link_state, output start_connect,
		output resync_time, output indicator_colour, output redraw_status, input ready);
	modport sink (input valid, input link_state, input start_connect,
		input resync_time, input indicator_colour, input redraw_status, output ready);
endinterface

// configuration write channel
interface lcrs_cfg_if
	import lcrs_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/lcrs_cfg.sv @@
`default_nettype none

module lcrs_cfg
	import lcrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lcrs_cfg_if.sink  cfg,
	output cfg_t      cfg_regs
);

	cfg_t cfg_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// register file, values truncated to register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval  <= CHECK_INTERVAL_RST;
			cfg_q.connect_timeout <= CONNECT_TIMEOUT_RST;
			cfg_q.max_retries     <= MAX_RETRIES_RST;
			cfg_q.recovery        <= RECOVERY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CHECK_INTERVAL:  cfg_q.check_interval  <= cfg.data[CHECK_W-1:0];
				CFG_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg.data[TIMEOUT_W-1:0];
				CFG_MAX_RETRIES:     cfg_q.max_retries     <= cfg.data[RETRY_W-1:0];
				CFG_RECOVERY:        cfg_q.recovery        <= cfg.data[RECOVERY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_regs = cfg_q;

endmodule

`default_nettype wire

@@ hdl/lcrs_fsm.sv @@
`default_nettype none

module lcrs_fsm
	import lcrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg_regs,
	input  wire logic                fire,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [TIME_W-1:0]   now_ms,
	input  wire logic                addr_changed,
	output result_t                  res
);

	link_mode_t          mode_q, mode_d;
	logic [TIME_W-1:0]   last_check_q, last_check_d;
	logic [TIME_W-1:0]   attempt_q, attempt_d;
	logic [TIME_W-1:0]   fail_q, fail_d;
	logic [RETRY_W-1:0]  retry_q, retry_d;
	logic [COLOUR_W-1:0] shown_q, shown_d;
	logic                pend_q, pend_d;

	logic [TIME_W-1:0]   since_check;
	logic [TIME_W-1:0]   since_attempt;
	logic [TIME_W-1:0]   since_fail;
	logic                check_due;
	logic                attempt_expired;
	logic                recovered;
	logic [RETRY_W-1:0]  retry_inc;
	logic                give_up;
	logic [COLOUR_W-1:0] colour;
	logic                start_d, resync_d, redraw_d;

	// wrapped elapsed times and limit compares
	assign since_check     = now_ms - last_check_q;
	assign since_attempt   = now_ms - attempt_q;
	assign since_fail      = now_ms - fail_q;
	assign check_due       = since_check >= {{(TIME_W-CHECK_W){1'b0}}, cfg_regs.check_interval};
	assign attempt_expired =
		since_attempt > {{(TIME_W-TIMEOUT_W){1'b0}}, cfg_regs.connect_timeout};
	assign recovered       = since_fail > {{(TIME_W-RECOVERY_W){1'b0}}, cfg_regs.recovery};

	// saturating retry count for a reconnect timeout
	assign retry_inc = (retry_q != RETRY_MAX) ? retry_q + RETRY_W'(1) : retry_q;
	assign give_up   = retry_inc >= cfg_regs.max_retries;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= LINK_DISC;
			last_check_q <= '0;
			attempt_q    <= '0;
			fail_q       <= '0;
			retry_q      <= '0;
			shown_q      <= COLOUR_DOWN;
			pend_q       <= 1'b1;
		end else if (fire) begin
			mode_q       <= mode_d;
			last_check_q <= last_check_d;
			attempt_q    <= attempt_d;
			fail_q       <= fail_d;
			retry_q      <= retry_d;
			shown_q      <= shown_d;
			pend_q       <= pend_d;
		end
	end

	// next state and result for the item in hand
	always_comb begin
		mode_d       = mode_q;
		last_check_d = last_check_q;
		attempt_d    = attempt_q;
		fail_d       = fail_q;
		retry_d      = retry_q;
		shown_d      = shown_q;
		pend_d       = pend_q;
		start_d      = 1'b0;
		resync_d     = 1'b0;
		redraw_d     = 1'b0;
		colour       = shown_q;
		case (opcode)
			OP_ADDR_ACQ: begin
				if (mode_q == LINK_CONNECTING || mode_q == LINK_RECONN) begin
					mode_d   = LINK_CONNECTED;
					retry_d  = '0;
					resync_d = 1'b1;
					pend_d   = 1'b1;
				end
			end
			OP_LINK_LOST: begin
				if (mode_q == LINK_CONNECTED) begin
					mode_d    = LINK_RECONN;
					attempt_d = now_ms;
					pend_d    = 1'b1;
				end
			end
			OP_CHECK: begin
				if (check_due) begin
					last_check_d = now_ms;
					case (mode_q)
						LINK_CONNECTING, LINK_RECONN: begin
							if (attempt_expired) begin
								if (mode_q == LINK_RECONN) begin
									retry_d = retry_inc;
								end
								if (mode_q == LINK_RECONN && give_up) begin
									mode_d = LINK_FAILED;
									fail_d = now_ms;
								end else begin
									start_d   = 1'b1;
									attempt_d = now_ms;
									mode_d    = LINK_RECONN;
								end
							end
						end
						LINK_CONNECTED: begin
							if (addr_changed) begin
								pend_d = 1'b1;
							end
						end
						LINK_FAILED: begin
							if (recovered) begin
								mode_d = LINK_DISC;
							end
						end
						default: begin
							mode_d    = LINK_CONNECTING;
							attempt_d = now_ms;
							retry_d   = '0;
							start_d   = 1'b1;
						end
					endcase
					// indicator refresh
					colour = colour_for(mode_d);
					if (colour != shown_q || pend_d) begin
						shown_d  = colour;
						redraw_d = 1'b1;
						pend_d   = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.link_state       = mode_d;
	assign res.start_connect    = start_d;
	assign res.resync_time      = resync_d;
	assign res.indicator_colour = shown_d;
	assign res.redraw_status    = redraw_d;

	// a redraw always consumes the pending flag
	a_redraw_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.redraw_status |=> !pend_q)
		else $error("pending redraw survived a redraw");

	// resync only when the link comes up
	a_resync_enters_connected: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.resync_time |=> mode_q == LINK_CONNECTED && retry_q == '0)
		else $error("resync without entering connected");

	// a connect command leaves an attempt running from this timestamp
	a_start_arms_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.start_connect |=>
			(mode_q == LINK_CONNECTING || mode_q == LINK_RECONN)
			&& attempt_q == $past(now_ms))
		else $error("connect command without an armed attempt");

	// the shown colour always tracks the mode after an acting check
	a_colour_tracks_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fire && opcode == OP_CHECK && check_due |=> shown_q == colour_for(mode_q))
		else $error("indicator colour out of step with link state");

endmodule

`default_nettype wire

@@ hdl/link_connect_retry_supervisor_top.sv @@
// channel  | dir | handshake      | payload
// ---------+-----+----------------+---------------------------------------------------
// item     | in  | valid / ready  | opcode, now_ms, addr_changed
// result   | out | valid / ready  | link_state, start_connect, resync_time,
//          |     |                | indicator_colour, redraw_status
// cfg      | in  | valid / ready  | index, data (register writes, always ready)
//
// one item per clock sustained while result.ready stays high; an item's result is
// registered twice before it is offered (input register, then result register) and
// holds there while stalled; the state update is a single pass of wrapped 32-bit
// subtract/compare logic between the two
// arst_n clears the link state, timers, colour and both stage valids at once
// a stalled result holds in the result register while the input register still
// takes one more item; item.ready drops only when both are full and result.ready is low
`default_nettype none

module link_connect_retry_supervisor_top
	import lcrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	lcrs_item_if.sink    item,
	lcrs_result_if.source result,
	lcrs_cfg_if.sink     cfg
);

	cfg_t    cfg_regs;
	result_t res;

	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                addr_changed_s1;
	logic                res_valid_q;
	result_t             res_q;
	logic                fire;

	// item in the input register moves on when the result register is free
	assign fire       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1       <= item.opcode;
			now_s1          <= item.now_ms;
			addr_changed_s1 <= item.addr_changed;
		end
	end

	lcrs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	lcrs_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_regs     (cfg_regs),
		.fire         (fire),
		.opcode       (opcode_s1),
		.now_ms       (now_s1),
		.addr_changed (addr_changed_s1),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.link_state       = res_q.link_state;
	assign result.start_connect    = res_q.start_connect;
	assign result.resync_time      = res_q.resync_time;
	assign result.indicator_colour = res_q.indicator_colour;
	assign result.redraw_status    = res_q.redraw_status;

	// every transfer in leaves the pipeline holding at least one item
	a_no_item_lost: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted item missing from input register");

	// a result is only produced from an occupied input register
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result without an item");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |-> !fire)
		else $error("stalled result overwritten");

endmodule

`default_nettype wire
